FILE: sv/sb_pkg.sv
// shared constants and elaboration-time helpers for the bearing pipeline
// no dependencies
package sb_pkg;

	// pi in unsigned q60
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	// pi rounded into q4.28, output clamp
	localparam longint OUT_MAX = 843314857;
	// fraction bits of the port angles
	localparam int IN_FRAC = 28;

	// atan(2^-i) in q62, power series; only evaluated for constants
	function automatic logic [63:0] atan_q62(input int i);
		logic [63:0] sum;
		logic [63:0] term;
		int e;
		sum = '0;
		if (i == 0) begin
			sum = PI_Q60;
		end else begin
			for (int k = 0; k < 32; k++) begin
				e = i * (2 * k + 1);
				if (e <= 62) begin
					term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
					if ((k & 1) != 0) begin
						sum = sum - term;
					end else begin
						sum = sum + term;
					end
				end
			end
		end
		return sum;
	endfunction

	// drop sh bits, then one more with round half up
	function automatic logic [63:0] round_q(input logic [63:0] q, input int sh);
		return ((q >> sh) + 64'd1) >> 1;
	endfunction

endpackage

FILE: sv/sb_pt_if.sv
// input channel: a pair of points, valid/ready handshake
// no dependencies
interface sb_pt_if;
	logic valid;
	logic ready;
	logic signed [31:0] lon_first;
	logic signed [31:0] lat_first;
	logic signed [31:0] lon_second;
	logic signed [31:0] lat_second;

	modport source(output valid, lon_first, lat_first, lon_second, lat_second, input ready);
	modport sink(input valid, lon_first, lat_first, lon_second, lat_second, output ready);
endinterface

FILE: sv/sb_res_if.sv
// output channel: bearing result, valid/ready handshake
// no dependencies
interface sb_res_if;
	logic valid;
	logic ready;
	logic signed [30:0] bearing;

	modport source(output valid, bearing, input ready);
	modport sink(input valid, bearing, output ready);
endinterface

FILE: sv/sb_sincos.sv
// pipelined sine/cosine: modulo-2pi reduction, quadrant fold, one cordic step per stage
// depends on sb_pkg
module sb_sincos #(
	parameter int ANGLE_BITS   = 32,
	parameter int CORDIC_STEPS = 28
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [ANGLE_BITS:0]   ang,
	output logic signed [ANGLE_BITS-1:0] cos_o,
	output logic signed [ANGLE_BITS-1:0] sin_o
);
	localparam int AW = ANGLE_BITS;
	localparam int F  = AW - 4;
	localparam int RW = AW + 4;
	localparam int N  = CORDIC_STEPS;

	localparam logic signed [RW-1:0] PI_R   = RW'(sb_pkg::round_q(sb_pkg::PI_Q60, 59 - F));
	localparam logic signed [RW-1:0] HALF_R = RW'(sb_pkg::round_q(sb_pkg::PI_Q60, 60 - F));
	localparam logic signed [RW-1:0] TWO_R  = PI_R + PI_R;
	localparam logic signed [RW-1:0] BIAS_R = TWO_R + TWO_R + TWO_R;
	localparam logic signed [RW-1:0] FOUR_R = TWO_R + TWO_R + TWO_R + TWO_R;
	localparam logic signed [RW-1:0] DBL_R  = TWO_R + TWO_R;
	localparam logic signed [AW-1:0] ONE    = AW'(64'd1 << F);

	logic signed [RW-1:0] z1_s, z2_s, z3_s;
	logic signed [RW-1:0] z2_d, z3_d;
	logic signed [AW-1:0] zf_d;
	logic                 flip_d;

	logic signed [AW-1:0] x_s [1:N];
	logic signed [AW-1:0] y_s [1:N];
	logic signed [AW-1:0] zc_s [0:N-1];
	logic                 fl_s [0:N];

	// bias by three turns so the remainder search only subtracts
	always_ff @(posedge clk) begin
		if (en) begin
			z1_s <= RW'(ang) + BIAS_R;
		end
	end

	always_comb begin
		z2_d = z1_s;
		if (z2_d >= FOUR_R) begin
			z2_d = z2_d - FOUR_R;
		end
		if (z2_d >= DBL_R) begin
			z2_d = z2_d - DBL_R;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z2_s <= z2_d;
		end
	end

	always_comb begin
		z3_d = z2_s;
		if (z3_d >= TWO_R) begin
			z3_d = z3_d - TWO_R;
		end
		if (z3_d > PI_R) begin
			z3_d = z3_d - TWO_R;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z3_s <= z3_d;
		end
	end

	// fold into the right half plane, negate both results later
	always_comb begin
		flip_d = 1'b0;
		zf_d   = AW'(z3_s);
		if (z3_s > HALF_R) begin
			zf_d   = AW'(z3_s - PI_R);
			flip_d = 1'b1;
		end else if (z3_s < -HALF_R) begin
			zf_d   = AW'(z3_s + PI_R);
			flip_d = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zc_s[0] <= zf_d;
			fl_s[0] <= flip_d;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic signed [AW-1:0] AT =
			AW'(sb_pkg::round_q(sb_pkg::atan_q62(k), 61 - F));
		logic signed [AW-1:0] xi, yi;
		if (k == 0) begin : g_first
			assign xi = ONE;
			assign yi = '0;
		end else begin : g_next
			assign xi = x_s[k];
			assign yi = y_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (zc_s[k] >= 0) begin
					x_s[k+1] <= xi - (yi >>> k);
					y_s[k+1] <= yi + (xi >>> k);
				end else begin
					x_s[k+1] <= xi + (yi >>> k);
					y_s[k+1] <= yi - (xi >>> k);
				end
				fl_s[k+1] <= fl_s[k];
			end
		end
		if (k < N - 1) begin : g_z
			always_ff @(posedge clk) begin
				if (en) begin
					zc_s[k+1] <= (zc_s[k] >= 0) ? zc_s[k] - AT : zc_s[k] + AT;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= fl_s[N] ? -x_s[N] : x_s[N];
			sin_o <= fl_s[N] ? -y_s[N] : y_s[N];
		end
	end

endmodule

FILE: sv/sb_vector.sv
// pipelined atan2: staged normalization, quadrant pre-rotation, one cordic step per stage
// depends on sb_pkg
module sb_vector #(
	parameter int ANGLE_BITS   = 32,
	parameter int CORDIC_STEPS = 28
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [ANGLE_BITS:0]   vx,
	input  logic signed [ANGLE_BITS:0]   vy,
	output logic signed [ANGLE_BITS-1:0] ang
);
	localparam int AW = ANGLE_BITS;
	localparam int F  = AW - 4;
	localparam int N  = CORDIC_STEPS;
	localparam int ZL = N + 4;

	localparam logic signed [AW-1:0] HALF_A = AW'(sb_pkg::round_q(sb_pkg::PI_Q60, 60 - F));

	logic signed [63:0] nx_s [0:3];
	logic signed [63:0] ny_s [0:3];
	logic [63:0]        nm_s [0:3];
	logic               zr_s [0:ZL];

	logic signed [63:0] x_s [0:N-1];
	logic signed [63:0] y_s [0:N-1];
	logic signed [AW-1:0] z_s [0:N];

	logic signed [63:0] ex, ey;
	logic [63:0]        ax, ay;

	always_comb begin
		ex = 64'(vx);
		ey = 64'(vy);
		ax = ex[63] ? 64'(-ex) : 64'(ex);
		ay = ey[63] ? 64'(-ey) : 64'(ey);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s[0] <= ex;
			ny_s[0] <= ey;
			nm_s[0] <= (ax > ay) ? ax : ay;
			zr_s[0] <= (ax == '0) && (ay == '0);
		end
	end

	// greedy left shift until the larger magnitude reaches 2^59
	for (genvar j = 0; j < 3; j++) begin : g_norm
		localparam int SH = 32 >> (2 * j);
		localparam int SL = 16 >> (2 * j);
		logic signed [63:0] tx, ty;
		logic [63:0]        tm;
		always_comb begin
			tx = nx_s[j];
			ty = ny_s[j];
			tm = nm_s[j];
			if (tm < (64'd1 << (60 - SH))) begin
				tx = tx <<< SH;
				ty = ty <<< SH;
				tm = tm << SH;
			end
			if (tm < (64'd1 << (60 - SL))) begin
				tx = tx <<< SL;
				ty = ty <<< SL;
				tm = tm << SL;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				nx_s[j+1] <= tx;
				ny_s[j+1] <= ty;
				nm_s[j+1] <= tm;
			end
		end
	end

	for (genvar j = 0; j < ZL; j++) begin : g_zero
		always_ff @(posedge clk) begin
			if (en) begin
				zr_s[j+1] <= zr_s[j];
			end
		end
	end

	// left half plane: rotate by a quarter turn first
	always_ff @(posedge clk) begin
		if (en) begin
			if (nx_s[3] < 0) begin
				if (ny_s[3] >= 0) begin
					x_s[0] <= ny_s[3];
					y_s[0] <= -nx_s[3];
					z_s[0] <= HALF_A;
				end else begin
					x_s[0] <= -ny_s[3];
					y_s[0] <= nx_s[3];
					z_s[0] <= -HALF_A;
				end
			end else begin
				x_s[0] <= nx_s[3];
				y_s[0] <= ny_s[3];
				z_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic signed [AW-1:0] AT =
			AW'(sb_pkg::round_q(sb_pkg::atan_q62(k), 61 - F));
		always_ff @(posedge clk) begin
			if (en) begin
				z_s[k+1] <= (y_s[k] >= 0) ? z_s[k] + AT : z_s[k] - AT;
			end
		end
		if (k < N - 1) begin : g_xy
			always_ff @(posedge clk) begin
				if (en) begin
					if (y_s[k] >= 0) begin
						x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
						y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					end else begin
						x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
						y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					end
				end
			end
		end
	end

	assign ang = zr_s[ZL] ? '0 : z_s[N];

endmodule

FILE: sv/spherical_bearing.sv
// top level: position angle of a second sphere point seen from a first
// depends on sb_pkg, sb_pt_if, sb_res_if, sb_sincos, sb_vector
//
//  channel  dir  beat payload
//  points   in   lon_first, lat_first, lon_second, lat_second (q4.28)
//  result   out  bearing (q3.28, within +/-pi)
//
// one beat in per cycle while the pipe is not frozen; the two cordic pipelines
// (sine/cosine, then atan2) run in series with the multiply stages.
// every stage advances together; when the output register holds an untaken beat the
// whole pipe freezes and points.ready drops. reset clears only the valid bits.
module spherical_bearing #(
	parameter int ANGLE_BITS   = 32,
	parameter int CORDIC_STEPS = 28
) (
	input  logic        clk,
	input  logic        arst_n,
	sb_pt_if.sink       points,
	sb_res_if.source    result
);
	localparam int AW  = ANGLE_BITS;
	localparam int F   = AW - 4;
	localparam int N   = CORDIC_STEPS;
	localparam int LSC = N + 5;
	localparam int LV  = N + 5;
	localparam int LT  = 1 + LSC + 3 + LV + 1;
	localparam int UPI = (F >= sb_pkg::IN_FRAC) ? F - sb_pkg::IN_FRAC : 0;
	localparam int DNI = (F < sb_pkg::IN_FRAC) ? sb_pkg::IN_FRAC - F : 0;
	localparam int DNO = UPI;
	localparam int UPO = DNI;
	localparam logic signed [63:0] RND = (DNO > 0) ? (64'sd1 <<< ((DNO > 0) ? DNO - 1 : 0)) : 64'sd0;
	localparam logic signed [AW-1:0] PI_F = AW'(sb_pkg::round_q(sb_pkg::PI_Q60, 59 - F));

	// cosine of zero through the same cordic, i.e. its gain
	function automatic logic signed [AW-1:0] cordic_gain();
		logic signed [63:0] x, y, z, dx, dy, at;
		x = 64'sd1 <<< F;
		y = '0;
		z = '0;
		for (int i = 0; i < N; i++) begin
			at = signed'(sb_pkg::round_q(sb_pkg::atan_q62(i), 61 - F));
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - at;
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + at;
			end
		end
		return AW'(x);
	endfunction

	localparam logic signed [AW-1:0] GAIN = cordic_gain();

	function automatic logic signed [AW-1:0] to_work(input logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		w = (w >>> DNI) <<< UPI;
		return AW'(w);
	endfunction

	// sign-magnitude product, rounded half away from zero
	function automatic logic signed [AW-1:0] mulq(input logic signed [AW-1:0] a,
	                                              input logic signed [AW-1:0] b);
		logic [AW-1:0]   ua, ub;
		logic [2*AW-1:0] p;
		ua = a[AW-1] ? AW'(-a) : AW'(a);
		ub = b[AW-1] ? AW'(-b) : AW'(b);
		p  = (2*AW)'(ua) * (2*AW)'(ub);
		p  = (p + ((2*AW)'(1) << (F - 1))) >> F;
		return (a[AW-1] ^ b[AW-1]) ? -AW'(p) : AW'(p);
	endfunction

	logic adv;
	logic v_s [1:LT];

	logic signed [AW:0]   b1_s, b2_s, da_s;
	logic signed [AW-1:0] a1_w, a2_w;
	logic signed [AW-1:0] cb1, sb1, cb2, sb2, cda, sda;
	logic signed [AW-1:0] p1_s, p2_s, y1_s, cda_s;
	logic signed [AW-1:0] q1_s, q2_s, yq_s;
	logic signed [AW:0]   x3_s, y3_s;
	logic signed [AW-1:0] z_v;
	logic signed [AW-1:0] zc;
	logic signed [63:0]   r;
	logic signed [30:0]   bear_s;

	assign adv          = !v_s[LT] || result.ready;
	assign points.ready = adv;
	assign result.valid = v_s[LT];
	assign result.bearing = bear_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LT; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s[1] <= points.valid;
			for (int k = 2; k <= LT; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	assign a1_w = to_work(points.lon_first);
	assign a2_w = to_work(points.lon_second);

	always_ff @(posedge clk) begin
		if (adv) begin
			b1_s <= (AW+1)'(to_work(points.lat_first));
			b2_s <= (AW+1)'(to_work(points.lat_second));
			da_s <= (AW+1)'(a2_w) - (AW+1)'(a1_w);
		end
	end

	sb_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_b1 (
		.clk(clk), .en(adv), .ang(b1_s), .cos_o(cb1), .sin_o(sb1)
	);

	sb_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_b2 (
		.clk(clk), .en(adv), .ang(b2_s), .cos_o(cb2), .sin_o(sb2)
	);

	sb_sincos #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_da (
		.clk(clk), .en(adv), .ang(da_s), .cos_o(cda), .sin_o(sda)
	);

	// every term ends up carrying gain cubed, which atan2 cancels
	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s  <= mulq(sb2, cb1);
			p2_s  <= mulq(cb2, sb1);
			y1_s  <= mulq(sda, cb2);
			cda_s <= cda;
			q1_s  <= mulq(p1_s, GAIN);
			q2_s  <= mulq(p2_s, cda_s);
			yq_s  <= mulq(y1_s, GAIN);
			x3_s  <= (AW+1)'(q1_s) - (AW+1)'(q2_s);
			y3_s  <= (AW+1)'(yq_s);
		end
	end

	sb_vector #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_vec (
		.clk(clk), .en(adv), .vx(x3_s), .vy(y3_s), .ang(z_v)
	);

	always_comb begin
		if (z_v > PI_F) begin
			zc = PI_F;
		end else if (z_v < -PI_F) begin
			zc = -PI_F;
		end else begin
			zc = z_v;
		end
		r = ((64'(zc) + RND) >>> DNO) <<< UPO;
		if (r > sb_pkg::OUT_MAX) begin
			r = sb_pkg::OUT_MAX;
		end else if (r < -sb_pkg::OUT_MAX) begin
			r = -sb_pkg::OUT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bear_s <= r[30:0];
		end
	end

endmodule

FILE: bench/bearing_checker.sv
// bearing checker: watches the points and result channels, predicts each bearing
// and compares it with what the block returns; depends on sb_pt_if, sb_res_if
`timescale 1ns / 1ps
module bearing_checker (
	input  logic clk,
	input  logic arst_n,
	sb_pt_if     points,
	sb_res_if    result,
	output int   mismatches,
	output int   outstanding
);

	localparam int FRAC = 28;
	localparam int STEPS = 28;
	localparam logic [63:0] PI_BITS = 64'h3243F6A8885A308D;
	localparam longint CLAMP = 843314857;

	longint atan_step[STEPS];
	longint pi_w;
	longint halfpi_w;
	logic signed [30:0] bearing_due[$];

	initial begin
		logic [63:0] sum;
		logic [63:0] term;
		int e;
		for (int i = 0; i < STEPS; i++) begin
			sum = (i == 0) ? PI_BITS : 64'd0;
			if (i != 0) begin
				for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
					e = i * (2 * k + 1);
					term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
					if (k % 2 == 1) sum = sum - term;
					else sum = sum + term;
				end
			end
			atan_step[i] = longint'(((sum >> (62 - FRAC - 1)) + 64'd1) >> 1);
		end
		pi_w = longint'(((PI_BITS >> (60 - FRAC - 1)) + 64'd1) >> 1);
		halfpi_w = longint'(((PI_BITS >> (60 - FRAC)) + 64'd1) >> 1);
	end

	// product rounded at FRAC bits, ties away from zero
	function automatic longint mul_frac(input longint a, input longint b);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [127:0] p;
		longint r;
		ua = (a < 0) ? 64'(-a) : 64'(a);
		ub = (b < 0) ? 64'(-b) : 64'(b);
		p = {64'd0, ua} * {64'd0, ub};
		p = p + (128'd1 << (FRAC - 1));
		r = longint'(p[FRAC +: 64]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic void rotate(input longint a, output longint c, output longint s);
		longint two;
		longint z;
		longint x;
		longint y;
		longint dx;
		longint dy;
		bit flip;
		two = 2 * pi_w;
		z = a % two;
		x = longint'(1) << FRAC;
		y = 0;
		flip = 0;
		if (z < 0) z += two;
		if (z > pi_w) z -= two;
		if (z > halfpi_w) begin
			z -= pi_w;
			flip = 1;
		end else if (z < -halfpi_w) begin
			z += pi_w;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step[i];
			end else begin
				x += dx; y -= dy; z += atan_step[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint vector_angle(input longint x0, input longint y0);
		longint x;
		longint y;
		longint z;
		longint t;
		longint dx;
		longint dy;
		logic [63:0] mag;
		logic [63:0] ax;
		logic [63:0] ay;
		x = x0;
		y = y0;
		z = 0;
		if (x == 0 && y == 0) return 0;
		ax = (x < 0) ? 64'(-x) : 64'(x);
		ay = (y < 0) ? 64'(-y) : 64'(y);
		mag = (ax > ay) ? ax : ay;
		while (mag < (64'd1 << 59)) begin
			x = x * 2; y = y * 2; mag = mag << 1;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = halfpi_w;
			end else begin
				x = -y; y = t; z = -halfpi_w;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_step[i];
			end else begin
				x -= dx; y += dy; z -= atan_step[i];
			end
		end
		return z;
	endfunction

	function automatic logic signed [30:0] predict_bearing(input logic signed [31:0] lon1,
			input logic signed [31:0] lat1, input logic signed [31:0] lon2,
			input logic signed [31:0] lat2);
		longint cb1, sb1, cb2, sb2, cda, sda, gain, gs, x, y, z;
		rotate(longint'(lat1), cb1, sb1);
		rotate(longint'(lat2), cb2, sb2);
		rotate(longint'(lon2) - longint'(lon1), cda, sda);
		rotate(0, gain, gs);
		x = mul_frac(mul_frac(sb2, cb1), gain) - mul_frac(mul_frac(cb2, sb1), cda);
		y = mul_frac(mul_frac(sda, cb2), gain);
		z = vector_angle(x, y);
		if (z > pi_w) z = pi_w;
		if (z < -pi_w) z = -pi_w;
		if (z > CLAMP) z = CLAMP;
		if (z < -CLAMP) z = -CLAMP;
		return z[30:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [30:0] want;
		if (!arst_n) begin
			mismatches <= 0;
			outstanding <= 0;
			bearing_due.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (bearing_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result beat: bearing %0d", result.bearing);
					mismatches <= mismatches + 1;
				end else begin
					want = bearing_due.pop_front();
					if (want !== result.bearing) begin
						if (mismatches < 10)
							$display("bearing mismatch: expected %0d got %0d",
								want, result.bearing);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (points.valid && points.ready)
				bearing_due.push_back(predict_bearing(points.lon_first, points.lat_first,
					points.lon_second, points.lat_second));
			outstanding <= bearing_due.size();
		end
	end

endmodule

FILE: bench/testbench.sv
// top of the bearing bench: clock, reset, point stimulus and result back-pressure
// depends on sb_pt_if, sb_res_if, spherical_bearing, bearing_checker
`timescale 1ns / 1ps
module testbench;

	localparam int PI28 = 843314857;
	localparam int HALF28 = 421657428;
	localparam int RANDOM_PAIRS = 1950;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int mismatches;
	int outstanding;
	bit idle_on;
	bit hold_req;
	int quiet_left;
	int stall_cycles;

	sb_pt_if points();
	sb_res_if result();

	spherical_bearing dut (.clk(clk), .arst_n(arst_n), .points(points), .result(result));

	bearing_checker checker_i (
		.clk(clk), .arst_n(arst_n), .points(points), .result(result),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// offer one pair, hold it until the beat is taken, then at times leave a gap
	task automatic send_pair(input int lon1, input int lat1, input int lon2, input int lat2);
		bit rdy;
		points.valid <= 1;
		points.lon_first <= lon1;
		points.lat_first <= lat1;
		points.lon_second <= lon2;
		points.lat_second <= lat2;
		do begin
			@(negedge clk);
			rdy = points.ready;
			@(posedge clk);
		end while (!rdy);
		if (idle_on && $urandom_range(0, 11) == 0) begin
			points.valid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	function automatic int any_angle();
		return int'($urandom);
	endfunction

	function automatic int sky_lon();
		return int'($urandom_range(0, 2 * PI28)) - PI28;
	endfunction

	function automatic int sky_lat();
		return int'($urandom_range(0, 2 * HALF28)) - HALF28;
	endfunction

	initial begin
		int lon1, lat1, lon2, lat2;
		idle_on = 1;
		hold_req = 0;
		arst_n = 0;
		points.valid <= 0;
		points.lon_first <= 0;
		points.lat_first <= 0;
		points.lon_second <= 0;
		points.lat_second <= 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// field extremes, poles, compass directions, coincident and antipodal points
		send_pair(0, 0, 0, 0);
		send_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_pair(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
		send_pair(32'h7FFFFFFF, 0, 32'h80000000, 0);
		send_pair(0, 0, 1000000, 0);
		send_pair(0, 0, -1000000, 0);
		send_pair(0, 0, 0, 1000000);
		send_pair(0, 0, 0, -1000000);
		send_pair(0, HALF28, 12345678, 0);
		send_pair(0, -HALF28, 12345678, 0);
		send_pair(5000000, 0, 5000000, HALF28);
		send_pair(0, 0, PI28, 0);
		send_pair(0, 0, -PI28, 0);
		send_pair(100000000, 200000000, 100000000, 200000000);
		send_pair(0, 100000000, PI28, -100000000);
		send_pair(-PI28, 0, PI28, 0);
		send_pair(0, 0, 1, 0);
		send_pair(0, 0, 0, 1);
		send_pair(300000000, -50000000, -300000000, 50000000);

		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			if (n == 500) hold_req = 1;
			if (n == 1100) begin
				points.valid <= 0;
				while (outstanding != 0) @(posedge clk);
			end
			if (n == 1650) idle_on = 0;
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					lon1 = any_angle(); lat1 = any_angle();
					lon2 = any_angle(); lat2 = any_angle();
				end
				7: begin
					lon1 = sky_lon(); lat1 = sky_lat(); lon2 = lon1; lat2 = lat1;
				end
				8: begin
					lon1 = sky_lon(); lat1 = sky_lat();
					lon2 = ($urandom_range(0, 1) == 0) ? lon1 : sky_lon();
					lat2 = ($urandom_range(0, 1) == 0) ? lat1 :
						(($urandom_range(0, 1) == 0) ? HALF28 : -HALF28);
				end
				9: begin
					// nearby points, small separations
					lon1 = sky_lon(); lat1 = sky_lat();
					lon2 = lon1 + int'($urandom_range(0, 2000)) - 1000;
					lat2 = lat1 + int'($urandom_range(0, 2000)) - 1000;
				end
				default: begin
					lon1 = sky_lon(); lat1 = sky_lat(); lon2 = sky_lon(); lat2 = sky_lat();
				end
			endcase
			send_pair(lon1, lat1, lon2, lat2);
		end
		points.valid <= 0;

		while (outstanding != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// result side back-pressure, including one long hold-off
	initial begin
		quiet_left = 0;
		result.ready <= 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result.ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
				result.ready <= 1;
			end else if (quiet_left > 0) begin
				quiet_left--;
			end else if (idle_on && $urandom_range(0, 15) == 0) begin
				quiet_left = $urandom_range(1, 9) - 1;
				result.ready <= 0;
			end else begin
				result.ready <= 1;
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	initial begin
		stall_cycles = 0;
		forever begin
			@(posedge clk);
			if ((points.valid && points.ready) || (result.valid && result.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule
